### rtl/core/tkf_pkg.sv
// Shared constants, types and state codes of the top-k frequent values block.
package tkf_pkg;

	// Table geometry and field widths
	localparam int TABLE_ENTRIES = 64;
	localparam int COUNT_WIDTH   = 16;
	localparam int VALUE_W       = 32;
	localparam int K_W           = 7;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
	localparam int REM_W         = (K_W > USED_W) ? K_W : USED_W;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [K_W-1:0]         K_RESET = K_W'(1);

	// One table entry: value, saturating count and first-seen order
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_WIDTH-1:0]    count;
		logic [IDX_W-1:0]          seq;
	} entry_t;

	// Commands broadcast along the row of cells
	typedef struct packed {
		logic             upd;    // reposition / insert an entry
		logic             drain;  // shift the row towards cell 0
		logic [IDX_W-1:0] pos;    // current slot of the entry being updated
	} cell_cmd_t;

	// Registered match result of the accepted item
	typedef struct packed {
		logic hit;
		logic sat;
		logic last;
	} match_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/tkf_cell.sv
// One slot of the sorted frequency table: match, reposition and drain.
module tkf_cell (
	input  logic                    clk,
	input  logic [tkf_pkg::IDX_W-1:0]  cell_idx,
	input  logic [tkf_pkg::USED_W-1:0] used,
	input  logic signed [tkf_pkg::VALUE_W-1:0] probe,
	input  tkf_pkg::cell_cmd_t      cmd,
	input  tkf_pkg::entry_t         new_ent,
	input  tkf_pkg::entry_t         prev_ent,
	input  logic                    prev_below,
	input  tkf_pkg::entry_t         next_ent,
	output tkf_pkg::entry_t         ent,
	output logic                    below,
	output logic                    hit
);

	tkf_pkg::entry_t ent_q;
	logic            occupied;
	logic            active;

	assign ent = ent_q;

	// occupancy follows from the fill count; no per-slot valid flag
	assign occupied = tkf_pkg::USED_W'(cell_idx) < used;
	assign hit      = occupied && (ent_q.value == probe);

	// ranks after the updated entry: lower count, or same count and seen later
	assign below = (ent_q.count < new_ent.count) ||
		((ent_q.count == new_ent.count) && (ent_q.seq > new_ent.seq));

	assign active = cmd.upd && (cell_idx <= cmd.pos);

	// slots ranked below open a gap: each takes its upper neighbour
	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			ent_q <= next_ent;
		end else if (active) begin
			if (prev_below) begin
				ent_q <= prev_ent;
			end else if (below || (cell_idx == cmd.pos)) begin
				ent_q <= new_ent;
			end
		end
	end

endmodule

### rtl/core/tkf_ctrl.sv
// Sequencer: handshakes, fill count, overflow flag, k register and result run.
module tkf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          cfg_we,
	input  logic [tkf_pkg::K_W-1:0]       cfg_wdata,
	input  tkf_pkg::match_t               match_s1,
	input  logic [tkf_pkg::IDX_W-1:0]     pos_s1,
	output tkf_pkg::cell_cmd_t            cmd,
	output logic [tkf_pkg::USED_W-1:0]    used,
	output logic                          overflowed,
	output logic                          run_last
);

	tkf_pkg::state_t state_q, state_nxt;

	logic [tkf_pkg::USED_W-1:0] used_q;
	logic                       overflow_q;
	logic [tkf_pkg::K_W-1:0]    k_q;
	logic [tkf_pkg::REM_W-1:0]  remaining_q;

	logic                       full;
	logic                       miss_ins;
	logic [tkf_pkg::USED_W-1:0] used_nxt;
	logic [tkf_pkg::REM_W-1:0]  want;
	logic                       out_take;
	logic                       clear_upd;
	logic                       clear_emit;

	assign full     = used_q == tkf_pkg::USED_W'(tkf_pkg::TABLE_ENTRIES);
	assign miss_ins = !match_s1.hit && !full;
	assign used_nxt = used_q + tkf_pkg::USED_W'(miss_ins);

	// number of results for this set
	always_comb begin
		if (tkf_pkg::REM_W'(k_q) < tkf_pkg::REM_W'(used_nxt)) begin
			want = tkf_pkg::REM_W'(k_q);
		end else begin
			want = tkf_pkg::REM_W'(used_nxt);
		end
	end

	assign out_take   = (state_q == tkf_pkg::ST_EMIT) && !out_stall;
	assign clear_upd  = (state_q == tkf_pkg::ST_UPDATE) && match_s1.last &&
		(want == '0);
	assign clear_emit = out_take && (remaining_q == tkf_pkg::REM_W'(1));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tkf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = tkf_pkg::ST_UPDATE;
				end
			end
			tkf_pkg::ST_UPDATE: begin
				if (match_s1.last && (want != '0)) begin
					state_nxt = tkf_pkg::ST_EMIT;
				end else begin
					state_nxt = tkf_pkg::ST_IDLE;
				end
			end
			tkf_pkg::ST_EMIT: begin
				if (clear_emit) begin
					state_nxt = tkf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tkf_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd.upd   = 1'b0;
		cmd.drain = 1'b0;
		cmd.pos   = match_s1.hit ? pos_s1 : used_q[tkf_pkg::IDX_W-1:0];
		case (state_q)
			tkf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			tkf_pkg::ST_UPDATE: begin
				cmd.upd = match_s1.hit ? !match_s1.sat : !full;
			end
			tkf_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.drain = !out_stall;
			end
			default: in_stall = 1'b1;
		endcase
	end

	assign used       = used_q;
	assign overflowed = overflow_q;
	assign run_last   = remaining_q == tkf_pkg::REM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tkf_pkg::ST_IDLE;
			used_q      <= '0;
			overflow_q  <= 1'b0;
			k_q         <= tkf_pkg::K_RESET;
			remaining_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			// fill count and overflow; emptied after each set
			if (clear_upd || clear_emit) begin
				used_q     <= '0;
				overflow_q <= 1'b0;
			end else if (state_q == tkf_pkg::ST_UPDATE) begin
				used_q <= used_nxt;
				if (!match_s1.hit && full) begin
					overflow_q <= 1'b1;
				end
			end
			// result countdown
			if ((state_q == tkf_pkg::ST_UPDATE) && match_s1.last) begin
				remaining_q <= want;
			end else if (out_take) begin
				remaining_q <= remaining_q - tkf_pkg::REM_W'(1);
			end
		end
	end

`ifndef SYNTH
	// a run never outlasts the table it drains
	a_run_within_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (remaining_q != '0) &&
		(remaining_q <= tkf_pkg::REM_W'(used_q)))
		else $error("result run longer than table");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= tkf_pkg::USED_W'(tkf_pkg::TABLE_ENTRIES))
		else $error("fill count beyond table size");

	// the table is empty once a run has been delivered
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		clear_emit |=> (used_q == '0) && !overflow_q)
		else $error("table not cleared after run");

	// an update always follows an accepted transaction
	a_update_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == tkf_pkg::ST_UPDATE))
		else $error("accepted transaction not processed");
`endif

endmodule

### rtl/core/top_k_frequent_values.sv
// Top level: row of table cells, match capture and sequencer.
//
// Counts a set of signed 32-bit values and, on the item flagged is_last, reports
// the min(k_wanted, distinct values) most frequent ones in decreasing count order,
// ties going to the value seen first. Each item is first matched against all stored
// entries in parallel, then its entry is moved to its new rank along the row of
// cells in the update state, so the table is always held sorted. After the last item
// results come straight out of cell 0, one per cycle while out_stall is low, as the
// row shifts towards the output; input is stalled until the run is delivered. The
// table empties at once when the run ends, with no clearing pass. Distinct values
// beyond 64 are dropped and flagged on table_overflowed; counts saturate at 65535.
module top_k_frequent_values (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [tkf_pkg::VALUE_W-1:0] item_value,
	input  logic                             is_last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [tkf_pkg::VALUE_W-1:0] top_value,
	output logic [tkf_pkg::COUNT_WIDTH-1:0]  top_count,
	output logic                             run_end,
	output logic                             table_overflowed,
	input  logic                             cfg_we,
	input  logic [tkf_pkg::K_W-1:0]          cfg_wdata
);

	localparam int N = tkf_pkg::TABLE_ENTRIES;

	tkf_pkg::entry_t    ent   [N];
	logic               below [N];
	logic               hit   [N];

	tkf_pkg::cell_cmd_t cmd;
	tkf_pkg::entry_t    new_ent;
	tkf_pkg::match_t    match_s1;
	logic [tkf_pkg::USED_W-1:0] used;
	logic               overflowed;
	logic               run_last;

	logic signed [tkf_pkg::VALUE_W-1:0] val_s1;
	logic [tkf_pkg::COUNT_WIDTH-1:0]    cnt_s1;
	logic [tkf_pkg::IDX_W-1:0]          seq_s1;
	logic [tkf_pkg::IDX_W-1:0]          pos_s1;

	logic                               any_hit;
	logic [tkf_pkg::COUNT_WIDTH-1:0]    hit_cnt;
	logic [tkf_pkg::IDX_W-1:0]          hit_seq;
	logic [tkf_pkg::IDX_W-1:0]          hit_pos;
	logic                               accept;

	assign accept = in_valid && !in_stall;

	// row of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		tkf_cell u_cell (
			.clk        (clk),
			.cell_idx   (tkf_pkg::IDX_W'(i)),
			.used       (used),
			.probe      (item_value),
			.cmd        (cmd),
			.new_ent    (new_ent),
			.prev_ent   ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i-1]),
			.prev_below ((i == 0) ? 1'b0 : below[(i == 0) ? 0 : i-1]),
			.next_ent   ((i == N-1) ? ent[N-1] : ent[(i == N-1) ? N-1 : i+1]),
			.ent        (ent[i]),
			.below      (below[i]),
			.hit        (hit[i])
		);
	end

	// gather the matching entry; at most one cell hits
	always_comb begin
		any_hit = 1'b0;
		hit_cnt = '0;
		hit_seq = '0;
		hit_pos = '0;
		for (int i = 0; i < N; i++) begin
			if (hit[i]) begin
				any_hit = 1'b1;
				hit_cnt = hit_cnt | ent[i].count;
				hit_seq = hit_seq | ent[i].seq;
				hit_pos = hit_pos | tkf_pkg::IDX_W'(i);
			end
		end
	end

	// capture the accepted transaction and its match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= '0;
		end else if (accept) begin
			match_s1.hit  <= any_hit;
			match_s1.sat  <= hit_cnt == tkf_pkg::CNT_MAX;
			match_s1.last <= is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1 <= item_value;
			cnt_s1 <= hit_cnt;
			seq_s1 <= hit_seq;
			pos_s1 <= hit_pos;
		end
	end

	// entry to place: bumped count, or a fresh entry at the end
	always_comb begin
		new_ent.value = val_s1;
		if (match_s1.hit) begin
			new_ent.count = cnt_s1 + tkf_pkg::CNT_ONE;
			new_ent.seq   = seq_s1;
		end else begin
			new_ent.count = tkf_pkg::CNT_ONE;
			new_ent.seq   = used[tkf_pkg::IDX_W-1:0];
		end
	end

	tkf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.match_s1   (match_s1),
		.pos_s1     (pos_s1),
		.cmd        (cmd),
		.used       (used),
		.overflowed (overflowed),
		.run_last   (run_last)
	);

	// results come from the head of the row
	assign top_value        = ent[0].value;
	assign top_count        = ent[0].count;
	assign run_end          = run_last;
	assign table_overflowed = overflowed;

endmodule
